FILE: rtl/fbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

  // widths that follow from the fixed field widths and the parameter ranges
  localparam int WALK_ADDR_W = 11;  // covers 8 banks of up to 128 columns plus a 127-byte overrun
  localparam int BANK_W      = 4;   // bottom bank of a shape reaches 15
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] LOW_BIT   = 8'h01;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PIXEL = 3'd1,
    CMD_RECT  = 3'd2,
    CMD_LINE  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WALK,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    logic                   status;
    logic                   clr;        // and out the mask instead of or-ing it
    logic [BANK_W-1:0]      bt;
    logic [BANK_W-1:0]      bb;
    logic [BANK_W-1:0]      bb_stop;
    logic [6:0]             w_last;
    logic [WALK_ADDR_W-1:0] row_base;
    logic [7:0]             top_edge;
    logic [7:0]             top_inner;
    logic [7:0]             bot_edge;
    logic [7:0]             bot_inner;
    logic [7:0]             mid_inner;
    logic [8:0]             raddr;
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_READ,
    BK_CLEAR,
    BK_RESP
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/fbd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fbd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [6:0] x;
  logic [5:0] y;
  logic [6:0] width;
  logic [5:0] height;
  logic [6:0] x_end;
  logic [5:0] y_end;
  logic       fill;
  logic       pixel_value;
  logic [8:0] read_address;

  modport source (
    output valid, command, x, y, width, height, x_end, y_end, fill, pixel_value,
    read_address,
    input  ready
  );
  modport sink (
    input  valid, command, x, y, width, height, x_end, y_end, fill, pixel_value,
    read_address,
    output ready
  );
endinterface

interface fbd_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_front
  import fbd_pkg::*;
#(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  fbd_cmd_if.sink cmd,
  input  logic    init_busy,
  input  logic    q_full,
  output logic    push,
  output op_t     op
);

  localparam int BANKS       = (ROWS + 7) / 8;
  localparam int FRAME_BYTES = COLUMNS * BANKS;
  localparam logic [7:0]             COL_LIM   = 8'(COLUMNS);
  localparam logic [6:0]             ROW_LIM   = 7'(ROWS);
  localparam logic [BANK_W-1:0]      LAST_BANK = BANK_W'(BANKS - 1);
  localparam logic [WALK_ADDR_W-1:0] COL_A     = WALK_ADDR_W'(COLUMNS);
  localparam logic [WALK_ADDR_W-1:0] FRAME_A   = WALK_ADDR_W'(FRAME_BYTES);

  logic                   is_line;
  logic                   line_ok;
  logic [6:0]             lx1, lx2;
  logic [5:0]             ly1, ly2;
  logic [6:0]             rx;
  logic [5:0]             ry;
  logic [7:0]             rw;
  logic [6:0]             rh;
  logic                   rfill;
  logic                   rect_bad;
  logic                   pix_ok;
  logic [6:0]             bottom;
  logic [BANK_W-1:0]      bt, bb, bb_stop;
  logic [2:0]             ys, bs;
  logic [7:0]             top_bit, bot_bit, top_fill, bot_fill;
  logic [WALK_ADDR_W-1:0] row_base;

  assign cmd.ready = !q_full && !init_busy;
  assign push      = cmd.valid && cmd.ready;

  // order the line ends, size the rectangle and build its masks and row base
  always_comb begin
    is_line = (cmd.command == CMD_LINE);
    line_ok = (cmd.x == cmd.x_end) || (cmd.y == cmd.y_end);
    lx1 = (cmd.x < cmd.x_end) ? cmd.x : cmd.x_end;
    lx2 = (cmd.x < cmd.x_end) ? cmd.x_end : cmd.x;
    ly1 = (cmd.y < cmd.y_end) ? cmd.y : cmd.y_end;
    ly2 = (cmd.y < cmd.y_end) ? cmd.y_end : cmd.y;
    rx    = is_line ? lx1 : cmd.x;
    ry    = is_line ? ly1 : cmd.y;
    rw    = is_line ? ({1'b0, lx2} - {1'b0, lx1} + 8'd1) : {1'b0, cmd.width};
    rh    = is_line ? ({1'b0, ly2} - {1'b0, ly1} + 7'd1) : {1'b0, cmd.height};
    rfill = is_line ? 1'b0 : cmd.fill;

    rect_bad = ({1'b0, rx} >= COL_LIM) || ({1'b0, ry} >= ROW_LIM) ||
               (rw == 8'd0) || (rh == 7'd0);
    pix_ok   = ({1'b0, cmd.x} < COL_LIM) && ({1'b0, cmd.y} < ROW_LIM);

    bottom  = {1'b0, ry} + rh - 7'd1;
    bt      = {1'b0, ry[5:3]};
    bb      = bottom[6:3];
    bb_stop = (bb > LAST_BANK) ? LAST_BANK : bb;
    ys      = ry[2:0];
    bs      = bottom[2:0];

    top_bit  = LOW_BIT << ys;
    bot_bit  = HIGH_BIT >> (3'd7 - bs);
    top_fill = FULL_BYTE << ys;
    bot_fill = FULL_BYTE >> (3'd7 - bs);
    if (rfill) begin
      top_bit = top_fill;
      bot_bit = bot_fill;
    end
    if (bt == bb) begin
      top_bit  = rfill ? (top_bit & bot_bit) : (top_bit | bot_bit);
      top_fill = top_fill & bot_fill;
    end

    row_base = WALK_ADDR_W'(ry[5:3]) * COL_A + WALK_ADDR_W'(rx);
  end

  always_comb begin
    op        = '0;
    op.kind   = OP_NONE;
    op.status = 1'b1;
    unique case (cmd.command) inside
      CMD_CLEAR: begin
        op.kind   = OP_CLEAR;
        op.status = 1'b0;
      end
      CMD_PIXEL: begin
        op.status = 1'b0;
        if (pix_ok) begin
          op.kind      = OP_WALK;
          op.clr       = !cmd.pixel_value;
          op.bt        = bt;
          op.bb        = bt;
          op.bb_stop   = bt;
          op.w_last    = 7'd0;
          op.row_base  = row_base;
          op.top_edge  = LOW_BIT << ys;
          op.top_inner = LOW_BIT << ys;
        end
      end
      CMD_RECT, CMD_LINE: begin
        if (!(is_line && !line_ok) && !rect_bad) begin
          op.kind      = OP_WALK;
          op.status    = 1'b0;
          op.bt        = bt;
          op.bb        = bb;
          op.bb_stop   = bb_stop;
          op.w_last    = 7'(rw - 8'd1);
          op.row_base  = row_base;
          op.top_edge  = top_fill;
          op.top_inner = top_bit;
          op.bot_edge  = bot_fill;
          op.bot_inner = bot_bit;
          op.mid_inner = rfill ? FULL_BYTE : 8'h00;
        end
      end
      CMD_READ: begin
        op.raddr = cmd.read_address;
        if (WALK_ADDR_W'(cmd.read_address) < FRAME_A) begin
          op.kind   = OP_READ;
          op.status = 1'b0;
        end
      end
      default: begin
        op.kind   = OP_NONE;
        op.status = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/fbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_queue
  import fbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  op_t               push_op,
  output logic              full,
  input  logic              pop,
  output op_t               head,
  output logic              head_valid,
  output logic [QCNT_W-1:0] count
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fbd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_back
  import fbd_pkg::*;
#(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  op_t       head,
  output logic      pop,
  output logic      init_busy,
  fbd_rsp_if.source rsp
);

  localparam int BANKS       = (ROWS + 7) / 8;
  localparam int FRAME_BYTES = COLUMNS * BANKS;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam logic [WALK_ADDR_W-1:0] COL_A   = WALK_ADDR_W'(COLUMNS);
  localparam logic [WALK_ADDR_W-1:0] FRAME_A = WALK_ADDR_W'(FRAME_BYTES);
  localparam logic [IDX_W-1:0]       LAST_IX = IDX_W'(FRAME_BYTES - 1);

  back_state_t            state, state_next;
  op_t                    cur;
  logic [BANK_W-1:0]      b;
  logic [6:0]             i;
  logic [WALK_ADDR_W-1:0] row_base;
  logic [WALK_ADDR_W-1:0] walk_addr;
  logic [WALK_ADDR_W-1:0] rd_addr;
  logic [7:0]             mask;
  logic                   edge_col;
  logic                   issue;
  logic                   clr_en;
  logic                   clr_last;
  logic                   out_load;
  logic [IDX_W-1:0]       clr_idx;

  logic [7:0]             mem [FRAME_BYTES];
  logic [7:0]             mem_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       wr_idx;
  logic [7:0]             wr_data;

  logic                   p_valid;
  logic [WALK_ADDR_W-1:0] p_addr;
  logic [7:0]             p_mask;
  logic                   p_inb;
  logic                   p_fwd;
  logic [7:0]             last_data;
  logic [7:0]             old_byte;
  logic [7:0]             new_byte;
  logic [7:0]             res_data;

  logic                   out_valid;
  logic                   out_status;
  logic [7:0]             out_data;

  assign init_busy     = (state == BK_INIT);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.read_data = out_data;

  assign walk_addr = row_base + WALK_ADDR_W'(i);
  assign clr_last  = (clr_idx == LAST_IX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    clr_en     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_INIT: begin
        clr_en = 1'b1;
        if (clr_last) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.kind)
            OP_NONE:  state_next = BK_RESP;
            OP_CLEAR: state_next = BK_CLEAR;
            OP_WALK:  state_next = BK_WALK;
            OP_READ:  state_next = BK_READ;
            default:  state_next = BK_RESP;
          endcase
        end
      end
      BK_WALK: begin
        issue = 1'b1;
        if ((i == cur.w_last) && (b == cur.bb_stop)) state_next = BK_DRAIN;
      end
      BK_DRAIN: state_next = BK_RESP;
      BK_READ:  state_next = BK_RESP;
      BK_CLEAR: begin
        clr_en = 1'b1;
        if (clr_last) state_next = BK_RESP;
      end
      BK_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // mask for the byte at the walk position
  always_comb begin
    edge_col = (i == 7'd0) || (i == cur.w_last);
    if (b == cur.bt) begin
      mask = edge_col ? cur.top_edge : cur.top_inner;
    end else if (b == cur.bb) begin
      mask = edge_col ? cur.bot_edge : cur.bot_inner;
    end else begin
      mask = edge_col ? FULL_BYTE : cur.mid_inner;
    end
  end

  // walk counters: one byte a cycle, bank by bank
  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head;
      i        <= 7'd0;
      b        <= head.bt;
      row_base <= head.row_base;
    end else if (issue) begin
      if (i == cur.w_last) begin
        i        <= 7'd0;
        b        <= b + BANK_W'(1);
        row_base <= row_base + COL_A;
      end else begin
        i <= i + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clr_en) begin
      clr_idx <= clr_last ? '0 : clr_idx + IDX_W'(1);
    end
  end

  // read-modify-write stage; forward when a byte is hit twice in a row
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p_addr    <= walk_addr;
    p_mask    <= mask;
    p_inb     <= (walk_addr < FRAME_A);
    p_fwd     <= p_valid && (walk_addr == p_addr);
    last_data <= new_byte;
  end

  always_comb begin
    old_byte = p_fwd ? last_data : mem_q;
    new_byte = cur.clr ? (old_byte & ~p_mask) : (old_byte | p_mask);
    rd_addr  = (state == BK_IDLE) ? WALK_ADDR_W'(head.raddr) : walk_addr;
    mem_we   = clr_en || (p_valid && p_inb);
    wr_idx   = clr_en ? clr_idx : p_addr[IDX_W-1:0];
    wr_data  = clr_en ? 8'h00 : new_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    mem_q <= mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= 8'h00;
    end else if (state == BK_READ) begin
      res_data <= mem_q;
    end
  end

  // output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= cur.status;
      out_data   <= res_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/banked_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Word
// cmd     | in  | command, x, y, width, height, x_end, y_end, fill, pixel_value, read_address
// rsp     | out | status, read_data (one word per command)
//
// Commands pass through a two-entry queue to a back end that walks the frame memory.
// The frame memory reads and writes one byte per cycle, at separate read and write
// addresses. After reset the memory is swept to zero; cmd.ready stays low during
// the sweep.
// The queue keeps taking commands, until full, while the back end works or a response waits.

module banked_framebuffer_draw_engine
  import fbd_pkg::*;
#(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic      clk,
  input  logic      rst,
  fbd_cmd_if.sink   cmd,
  fbd_rsp_if.source rsp
);

  logic              push;
  op_t               push_op;
  logic              q_full;
  logic              pop;
  op_t               head;
  logic              head_valid;
  logic [QCNT_W-1:0] q_count;
  logic              init_busy;

  fbd_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .cmd       (cmd),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .op        (push_op)
  );

  fbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  fbd_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .init_busy  (init_busy),
    .rsp        (rsp)
  );

  a_reset_sweep: assert property (@(posedge clk) rst |=> init_busy)
    else $error("memory sweep not started after reset");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !(cmd.valid && cmd.ready))
    else $error("command accepted during memory sweep");

  a_queue_empty_in_sweep: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (q_count == '0))
    else $error("queue holds commands during memory sweep");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");

endmodule

`default_nettype wire

FILE: verif/banked_framebuffer_draw_engine_tb.sv
`timescale 1ns / 1ps

module banked_framebuffer_draw_engine_tb;
  import fbd_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int COLUMNS     = 84;
  localparam int ROWS        = 48;
  localparam int BANKS       = (ROWS + 7) / 8;
  localparam int FRAME_BYTES = COLUMNS * BANKS;
  localparam int RESET_CYCLES = 12;
  localparam int PHASE_WORDS  = 340;
  localparam int LONG_HOLD    = 700;
  localparam int TAIL_CYCLES  = 100;

  // command codes the block does not define
  localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  localparam bit ST_OK  = 1'b0;
  localparam bit ST_ERR = 1'b1;
  localparam bit KNOWN   = 1'b1;
  localparam bit PREDICT = 1'b0;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] x;
    logic [5:0] y;
    logic [6:0] width;
    logic [5:0] height;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic       fill;
    logic       pixel_value;
    logic [8:0] read_address;
  } draw_word_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } draw_reply_t;

  typedef struct packed {
    draw_word_t  word;
    logic        known;
    draw_reply_t reply;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  fbd_cmd_if cmd_bus ();
  fbd_rsp_if rsp_bus ();

  banked_framebuffer_draw_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [7:0]  shadow_frame [FRAME_BYTES];
  draw_reply_t expected_replies [$];
  script_row_t script [$];

  int send_idle_pct = 31;
  int recv_idle_pct = 83;
  bit hold_request  = 1'b0;
  int fail_count     = 0;
  int replies_checked = 0;
  int words_by_cmd [8];

  // ---------------------------------------------------------------- predictor

  function automatic void or_into(int addr, logic [7:0] mask);
    if (addr < FRAME_BYTES) shadow_frame[addr] = shadow_frame[addr] | mask;
  endfunction

  function automatic void paint_bank_row(int pos, int w, logic [7:0] side_mask,
                                         logic [7:0] inner_mask);
    for (int i = 0; i < w; i++) begin
      or_into(pos + i, (i == 0 || i == w - 1) ? side_mask : inner_mask);
    end
  endfunction

  // returns the status bit; draws nothing on a bad origin or empty size
  function automatic logic paint_rect(int x, int y, int w, int h, logic filled);
    int bottom, bt, bb, pos;
    logic [7:0] top_line, bot_line, top_span, bot_span;
    if (x >= COLUMNS || y >= ROWS || w == 0 || h == 0) return ST_ERR;
    bottom   = y + h - 1;
    bt       = y / 8;
    bb       = bottom / 8;
    top_line = LOW_BIT << (y % 8);
    bot_line = HIGH_BIT >> (7 - bottom % 8);
    top_span = FULL_BYTE << (y % 8);
    bot_span = FULL_BYTE >> (7 - bottom % 8);
    if (filled) begin
      top_line = top_span;
      bot_line = bot_span;
    end
    if (bt == bb) begin
      top_line = filled ? (top_line & bot_line) : (top_line | bot_line);
      top_span = top_span & bot_span;
    end
    pos = bt * COLUMNS + x;
    paint_bank_row(pos, w, top_span, top_line);
    pos += COLUMNS;
    for (int b = bt + 1; b < bb; b++) begin
      if (filled) begin
        for (int i = 0; i < w; i++) or_into(pos + i, FULL_BYTE);
      end else begin
        or_into(pos, FULL_BYTE);
        or_into(pos + w - 1, FULL_BYTE);
      end
      pos += COLUMNS;
    end
    if (bb > bt) paint_bank_row(pos, w, bot_span, bot_line);
    return ST_OK;
  endfunction

  function automatic draw_reply_t apply_command(draw_word_t w);
    draw_reply_t r;
    int a, x1, x2, y1, y2;
    logic [7:0] mask;
    r = '0;
    case (w.command)
      CMD_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      CMD_PIXEL: begin
        // off-screen pixels are ignored but still succeed
        if (w.x < COLUMNS && w.y < ROWS) begin
          a    = (w.y / 8) * COLUMNS + w.x;
          mask = LOW_BIT << (w.y % 8);
          if (w.pixel_value) shadow_frame[a] = shadow_frame[a] | mask;
          else               shadow_frame[a] = shadow_frame[a] & ~mask;
        end
      end
      CMD_RECT: begin
        r.status = paint_rect(w.x, w.y, w.width, w.height, w.fill);
      end
      CMD_LINE: begin
        if (w.x == w.x_end || w.y == w.y_end) begin
          x1 = (w.x < w.x_end) ? w.x : w.x_end;
          x2 = (w.x < w.x_end) ? w.x_end : w.x;
          y1 = (w.y < w.y_end) ? w.y : w.y_end;
          y2 = (w.y < w.y_end) ? w.y_end : w.y;
          r.status = paint_rect(x1, y1, x2 - x1 + 1, y2 - y1 + 1, 1'b0);
        end else begin
          r.status = ST_ERR;
        end
      end
      CMD_READ: begin
        if (w.read_address < FRAME_BYTES) r.read_data = shadow_frame[w.read_address];
        else                              r.status = ST_ERR;
      end
      default: r.status = ST_ERR;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic script_row_t row(logic [2:0] c, int x, int y, int w, int h,
                                      int xe, int ye, int fl, int pv, int ra,
                                      bit known, bit st, logic [7:0] rd);
    script_row_t s;
    s.word.command      = c;
    s.word.x            = 7'(x);
    s.word.y            = 6'(y);
    s.word.width        = 7'(w);
    s.word.height       = 6'(h);
    s.word.x_end        = 7'(xe);
    s.word.y_end        = 6'(ye);
    s.word.fill         = 1'(fl);
    s.word.pixel_value  = 1'(pv);
    s.word.read_address = 9'(ra);
    s.known             = known;
    s.reply.status      = st;
    s.reply.read_data   = rd;
    return s;
  endfunction

  // offer one word, hold it until taken, then record what it must produce
  task automatic issue(draw_word_t w, bit known, draw_reply_t fixed);
    draw_reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command      <= w.command;
    cmd_bus.x            <= w.x;
    cmd_bus.y            <= w.y;
    cmd_bus.width        <= w.width;
    cmd_bus.height       <= w.height;
    cmd_bus.x_end        <= w.x_end;
    cmd_bus.y_end        <= w.y_end;
    cmd_bus.fill         <= w.fill;
    cmd_bus.pixel_value  <= w.pixel_value;
    cmd_bus.read_address <= w.read_address;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    predicted = apply_command(w);
    expected_replies.push_back(known ? fixed : predicted);
    words_by_cmd[w.command]++;
  endtask

  task automatic drain_replies();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int hold_left;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    draw_reply_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none, got status %0b read_data %02h",
                 $time, rsp_bus.status, rsp_bus.read_data);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (rsp_bus.status !== want.status) begin
          $display("%0t: status mismatch: expected %0b, got %0b",
                   $time, want.status, rsp_bus.status);
          fail_count++;
        end
        if (rsp_bus.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch: expected %02h, got %02h",
                   $time, want.read_data, rsp_bus.read_data);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    draw_word_t  w;
    logic [63:0] noise;
    int          pick, r;
    int          send_pct [3];
    int          recv_pct [3];

    send_pct = '{31, 83, 0};
    recv_pct = '{83, 31, 0};

    rst                  = 1'b1;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command      = '0;
    cmd_bus.x            = '0;
    cmd_bus.y            = '0;
    cmd_bus.width        = '0;
    cmd_bus.height       = '0;
    cmd_bus.x_end        = '0;
    cmd_bus.y_end        = '0;
    cmd_bus.fill         = 1'b0;
    cmd_bus.pixel_value  = 1'b0;
    cmd_bus.read_address = '0;
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;

    // reads after reset, pixels set and cleared, off-screen pixel, rejected rectangles, full fill, clear
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 503, KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 504, KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 511, KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_PIXEL,   0,  0,   0,  0,  0,  0, 0, 1, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 0,   KNOWN, ST_OK,  LOW_BIT));
    script.push_back(row(CMD_PIXEL,  83, 47,   0,  0,  0,  0, 0, 1, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 503, KNOWN, ST_OK,  HIGH_BIT));
    script.push_back(row(CMD_PIXEL,   0,  0,   0,  0,  0,  0, 0, 0, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_PIXEL, 127, 63,   0,  0,  0,  0, 0, 1, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_RECT,   84,  0,   5,  5,  0,  0, 1, 0, 0,   KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_RECT,    0, 48,   5,  5,  0,  0, 0, 0, 0,   KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_RECT,    5,  5,   0,  5,  0,  0, 1, 0, 0,   KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_RECT,    5,  5,   5,  0,  0,  0, 0, 0, 0,   KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_RECT,    0,  0,  84, 48,  0,  0, 1, 0, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 250, KNOWN, ST_OK,  FULL_BYTE));
    script.push_back(row(CMD_CLEAR,   0,  0,   0,  0,  0,  0, 0, 0, 0,   KNOWN, ST_OK,  8'h00));
    script.push_back(row(CMD_RECT,    3,  2,  10, 20,  0,  0, 0, 0, 0,   PREDICT, ST_OK, 8'h00));
    script.push_back(row(CMD_READ,    0,  0,   0,  0,  0,  0, 0, 0, 87,  PREDICT, ST_OK, 8'h00));
    // runs past the right and bottom edges: wraps and drops
    script.push_back(row(CMD_RECT,   80, 45, 127, 63,  0,  0, 0, 0, 0,   PREDICT, ST_OK, 8'h00));
    script.push_back(row(CMD_LINE,    1,  1,   0,  0,  2,  2, 0, 0, 0,   KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_LINE,   70, 10,   0,  0,  5, 10, 1, 0, 0,   PREDICT, ST_OK, 8'h00));
    script.push_back(row(CMD_LINE,    5, 40,   0,  0,  5,  3, 0, 0, 0,   PREDICT, ST_OK, 8'h00));
    script.push_back(row(CMD_LINE,  100,  5,   0,  0, 100, 9, 0, 0, 0,   KNOWN, ST_ERR, 8'h00));
    script.push_back(row(CMD_UNDEF_LO, 0, 0,   0,  0,  0,  0, 0, 0, 0,   KNOWN, ST_ERR, 8'h00));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    foreach (script[i]) issue(script[i].word, script[i].known, script[i].reply);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      // stall the reply side while words keep coming so the queue backs up
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        noise = {$urandom, $urandom};
        w     = noise[$bits(draw_word_t)-1:0];
        pick  = $urandom_range(99);
        r     = $urandom_range(99);
        if (pick < 4) begin
          w.command = CMD_CLEAR;
        end else if (pick < 24) begin
          w.command = CMD_PIXEL;
          if (r < 85) begin
            w.x = 7'($urandom_range(COLUMNS - 1, 0));
            w.y = 6'($urandom_range(ROWS - 1, 0));
          end
        end else if (pick < 50) begin
          w.command = CMD_RECT;
          if ($urandom_range(9) != 0) begin
            w.x = 7'($urandom_range(COLUMNS - 1, 0));
            w.y = 6'($urandom_range(ROWS - 1, 0));
          end
          // keep most shapes small; big ones walk hundreds of bytes
          if (r >= 3 && r < 8) begin
            w.width  = 7'($urandom_range(2, 0));
            w.height = 6'($urandom_range(2, 0));
          end else if (r >= 8) begin
            w.width  = 7'($urandom_range(16, 1));
            w.height = 6'($urandom_range(20, 1));
          end
        end else if (pick < 66) begin
          w.command = CMD_LINE;
          if ($urandom_range(9) != 0) begin
            w.x = 7'($urandom_range(COLUMNS - 1, 0));
            w.y = 6'($urandom_range(ROWS - 1, 0));
          end
          if (r < 45) begin
            w.y_end = w.y;
          end else if (r < 85) begin
            w.x_end = w.x;
          end else if (r < 90) begin
            w.x_end = w.x;
            w.y_end = w.y;
          end
        end else if (pick < 96) begin
          w.command = CMD_READ;
          if (r < 90) w.read_address = 9'($urandom_range(FRAME_BYTES - 1, 0));
        end else begin
          w.command = 3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
        end
        issue(w, PREDICT, '0);
      end
      // pause the sender until every reply is back
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d clear, %0d pixel, %0d rect, %0d line, %0d read, %0d undefined words",
             words_by_cmd[CMD_CLEAR], words_by_cmd[CMD_PIXEL], words_by_cmd[CMD_RECT],
             words_by_cmd[CMD_LINE], words_by_cmd[CMD_READ],
             words_by_cmd[5] + words_by_cmd[6] + words_by_cmd[7]);
    $display("%0d replies checked over three idle mixes and a %0d-cycle reply hold-off",
             replies_checked, LONG_HOLD);
    if (fail_count == 0) begin
      $display("banked_framebuffer_draw_engine test passed");
    end else begin
      $display("banked_framebuffer_draw_engine test failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("timeout with %0d replies outstanding", expected_replies.size());
    $display("banked_framebuffer_draw_engine test failed");
    $finish;
  end

endmodule
